FILE: hw/rtl/dp2w_pkg.sv
// ----------------------------------------------------------------------------
// dp2w_pkg
// Shared types, register indexes, reset values and fixed-point helpers for
// the depth pixel to world point pipeline.
// ----------------------------------------------------------------------------
package dp2w_pkg;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_PRINCIPAL_POINT     = 3'd0,
      REG_INVERSE_FOCAL       = 3'd1,
      REG_INVERSE_DEPTH_SCALE = 3'd2,
      REG_ROTATION_ROW_X      = 3'd3,
      REG_ROTATION_ROW_Y      = 3'd4,
      REG_ROTATION_ROW_Z      = 3'd5,
      REG_TRANSLATION_XY      = 3'd6,
      REG_TRANSLATION_Z       = 3'd7
   } csr_index_type;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;
   localparam int ROT_BITS       = 18;
   localparam int ROT_ROW_BITS   = 3 * ROT_BITS;
   localparam int COORD_BITS     = 32;
   localparam int COLOR_BITS     = 8;
   localparam int DEPTH_BITS     = 16;
   localparam int RSP_DATA_BITS  = 3 * COORD_BITS + 3 * COLOR_BITS;

   // Reset values: cx 319.5, cy 239.5, 1/fx, 1/fy (fy negative), 1/5000 m,
   // identity rotation, zero translation
   localparam logic [31:0] PRINCIPAL_POINT_RST     = 32'h0EF8_13F8;
   localparam logic [63:0] INVERSE_FOCAL_RST       = 64'hFFFF_7777_0000_8831;
   localparam logic [31:0] INVERSE_DEPTH_SCALE_RST = 32'd858993;
   localparam logic [ROT_ROW_BITS-1:0] ROTATION_ROW_X_RST = 54'h1 << 16;
   localparam logic [ROT_ROW_BITS-1:0] ROTATION_ROW_Y_RST = 54'h1 << 34;
   localparam logic [ROT_ROW_BITS-1:0] ROTATION_ROW_Z_RST = 54'h1 << 52;

   typedef struct packed {
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] blue;
   } color_type;

   // Camera intrinsics as used by the back-projection stages
   typedef struct packed {
      logic [15:0]        cx;
      logic [15:0]        cy;
      logic signed [31:0] inv_fx;
      logic signed [31:0] inv_fy;
      logic [31:0]        inv_depth_scale;
   } cam_cfg_type;

   // Camera pose: rotation rows of Q1.16 entries, Q15.16 translation
   typedef struct packed {
      logic [2:0][2:0][ROT_BITS-1:0] rot;
      logic [2:0][COORD_BITS-1:0]    trans;
   } pose_cfg_type;

   // Camera-frame point with its color
   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] z;
      color_type             color;
   } cam_point_type;

   // Round half up by a right shift, then saturate to signed 32 bits
   function automatic logic [31:0] round_sat(input logic signed [63:0] value,
                                             input int shift);
      logic signed [63:0] q;
      begin
         q = (value + (64'sd1 <<< (shift - 1))) >>> shift;
         if (q > 64'sd2147483647) begin
            round_sat = 32'h7FFF_FFFF;
         end else if (q < -64'sd2147483648) begin
            round_sat = 32'h8000_0000;
         end else begin
            round_sat = q[31:0];
         end
      end
   endfunction

endpackage

FILE: hw/rtl/dp2w_backproject.sv
// ----------------------------------------------------------------------------
// dp2w_backproject
// Five-stage pipeline from pixel and raw depth to a camera-frame point.
// ----------------------------------------------------------------------------
module dp2w_backproject
   import dp2w_pkg::*;
#(
   parameter int PIXEL_INDEX_BITS = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cam_cfg_type                 cam_cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [PIXEL_INDEX_BITS-1:0] in_column,
   input  logic [PIXEL_INDEX_BITS-1:0] in_row,
   input  logic [DEPTH_BITS-1:0]       in_depth,
   input  color_type                   in_color,
   output logic                        out_valid,
   input  logic                        out_ready,
   output cam_point_type               out_point
);

   localparam int STAGES   = 5;
   localparam int PIX_Q4   = PIXEL_INDEX_BITS + 4;
   localparam int DU_BITS  = ((PIX_Q4 > 16) ? PIX_Q4 : 16) + 1;
   localparam int RAY_BITS = DU_BITS + 32;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES:0]   ready;

   // Stage payload registers
   color_type                 color_ff [STAGES];
   logic [47:0]               zprod_ff;
   logic signed [DU_BITS-1:0] du_ff, dv_ff;
   logic [30:0]               z_ff [1:STAGES-1];
   logic signed [RAY_BITS-1:0] rprod_x_ff, rprod_y_ff;
   logic [31:0]               ray_x_ff, ray_y_ff;
   logic signed [63:0]        cprod_x_ff, cprod_y_ff;
   logic [31:0]               cam_x_ff, cam_y_ff;

   logic [47:0]               zprod_in;
   logic signed [DU_BITS-1:0] du_in, dv_in;
   logic [48:0]               zsum;
   logic [30:0]               z_in;
   logic signed [RAY_BITS-1:0] rprod_x_in, rprod_y_in;
   logic signed [63:0]        cprod_x_in, cprod_y_in;

   // A stage takes new data when it is empty or its successor moves on
   always_comb begin
      ready[STAGES] = out_ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   // Drop pixels without a depth measurement at the entry
   always_comb begin
      valid_in[0] = in_valid && (in_depth != '0);
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // Stage 0: depth product and pixel offsets from the principal point
   assign zprod_in = 48'(in_depth) * 48'(cam_cfg.inv_depth_scale);
   assign du_in = $signed(DU_BITS'({in_column, 4'b0000})) - $signed(DU_BITS'(cam_cfg.cx));
   assign dv_in = $signed(DU_BITS'({in_row, 4'b0000})) - $signed(DU_BITS'(cam_cfg.cy));

   // Stage 1: round and clamp z, ray products
   assign zsum = 49'(zprod_ff) + 49'd32768;
   assign z_in = (zsum[48:47] != 2'b00) ? 31'h7FFF_FFFF : zsum[46:16];
   assign rprod_x_in = du_ff * RAY_BITS'(cam_cfg.inv_fx);
   assign rprod_y_in = dv_ff * RAY_BITS'(cam_cfg.inv_fy);

   // Stage 3: scale rays by depth
   assign cprod_x_in = $signed(ray_x_ff) * $signed({1'b0, z_ff[2]});
   assign cprod_y_in = $signed(ray_y_ff) * $signed({1'b0, z_ff[2]});

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         color_ff[0] <= in_color;
         zprod_ff    <= zprod_in;
         du_ff       <= du_in;
         dv_ff       <= dv_in;
      end
      if (ready[1]) begin
         color_ff[1] <= color_ff[0];
         z_ff[1]     <= z_in;
         rprod_x_ff  <= rprod_x_in;
         rprod_y_ff  <= rprod_y_in;
      end
      if (ready[2]) begin
         color_ff[2] <= color_ff[1];
         z_ff[2]     <= z_ff[1];
         ray_x_ff    <= round_sat(64'(rprod_x_ff), 12);
         ray_y_ff    <= round_sat(64'(rprod_y_ff), 12);
      end
      if (ready[3]) begin
         color_ff[3] <= color_ff[2];
         z_ff[3]     <= z_ff[2];
         cprod_x_ff  <= cprod_x_in;
         cprod_y_ff  <= cprod_y_in;
      end
      if (ready[4]) begin
         color_ff[4] <= color_ff[3];
         z_ff[4]     <= z_ff[3];
         cam_x_ff    <= round_sat(cprod_x_ff, 16);
         cam_y_ff    <= round_sat(cprod_y_ff, 16);
      end
   end

   assign in_ready        = ready[0];
   assign out_valid       = valid_ff[STAGES-1];
   assign out_point.x     = cam_x_ff;
   assign out_point.y     = cam_y_ff;
   assign out_point.z     = {1'b0, z_ff[STAGES-1]};
   assign out_point.color = color_ff[STAGES-1];

endmodule

FILE: hw/rtl/dp2w_transform.sv
// ----------------------------------------------------------------------------
// dp2w_transform
// Two-stage rigid transform: nine rotation products, then sum with the
// translation, round and saturate into the output register.
// ----------------------------------------------------------------------------
module dp2w_transform
   import dp2w_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  pose_cfg_type  pose_cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  cam_point_type in_point,
   output logic          out_valid,
   input  logic          out_ready,
   output cam_point_type out_point
);

   localparam int PROD_BITS = ROT_BITS + COORD_BITS;

   logic [1:0] valid_ff;
   logic [2:0] ready;

   logic signed [PROD_BITS-1:0] prod_ff [3][3];
   logic signed [PROD_BITS-1:0] prod_in [3][3];
   color_type                   color_ff [2];
   logic [2:0][COORD_BITS-1:0]  world_ff;
   logic [2:0][COORD_BITS-1:0]  cam_p;
   logic signed [63:0]          acc [3];

   assign ready[2] = out_ready;
   assign ready[1] = !valid_ff[1] || ready[2];
   assign ready[0] = !valid_ff[0] || ready[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) begin
            valid_ff[0] <= in_valid;
         end
         if (ready[1]) begin
            valid_ff[1] <= valid_ff[0];
         end
      end
   end

   assign cam_p[0] = in_point.x;
   assign cam_p[1] = in_point.y;
   assign cam_p[2] = in_point.z;

   // Stage 0: rotation products, one per matrix entry
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = $signed(pose_cfg.rot[i][j]) * $signed(cam_p[j]);
         end
      end
   end

   // Stage 1: add translation in Q32 and reduce to Q16
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = 64'(prod_ff[i][0]) + 64'(prod_ff[i][1]) + 64'(prod_ff[i][2])
                + (64'($signed(pose_cfg.trans[i])) <<< 16);
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         prod_ff     <= prod_in;
         color_ff[0] <= in_point.color;
      end
      if (ready[1]) begin
         color_ff[1] <= color_ff[0];
         for (int i = 0; i < 3; i++) begin
            world_ff[i] <= round_sat(acc[i], 16);
         end
      end
   end

   assign in_ready        = ready[0];
   assign out_valid       = valid_ff[1];
   assign out_point.x     = world_ff[0];
   assign out_point.y     = world_ff[1];
   assign out_point.z     = world_ff[2];
   assign out_point.color = color_ff[1];

endmodule

FILE: hw/rtl/depth_pixel_to_world_point.sv
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point
// Back-projects depth pixels through a pinhole model and moves the point
// into the world frame with a configurable camera pose.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ carries one pixel per transfer: column, row, raw depth and color.
//    A pixel with depth zero is taken and yields no result.
//  - rsp_ carries one world point per valid pixel: Q15.16 x, y, z and the
//    pixel color, in input order.
//  - csr_ writes a register with no read-back; write only while no
//    pixel is in flight.
//  - A req_ transfer reaches rsp_tvalid through five stages of
//    back-projection (depth product, ray product, ray rounding, ray times z,
//    rounding) and two of the pose transform (rotation products, sum and
//    saturation into the output register).
//  - Throughput is one pixel per cycle while rsp_tready is high; every
//    product is registered before it is rounded or summed.
//  - When rsp_tready is low the output register holds its point; the empty
//    stages behind it keep filling, so req_tready falls only once all seven
//    stages hold a point.
//  - Reset clears the pipeline valid bits and loads the default intrinsics
//    (cx 319.5, cy 239.5, 1/fx, negative 1/fy, 1/5000 m depth unit) and an
//    identity pose.
// ----------------------------------------------------------------------------
module depth_pixel_to_world_point
   import dp2w_pkg::*;
#(
   parameter int PIXEL_INDEX_BITS = 12,
   localparam int REQ_DATA_BITS =
      ((2 * PIXEL_INDEX_BITS + DEPTH_BITS + 3 * COLOR_BITS + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // configuration write port
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   // pixel stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,  // column, row, depth, blue, green, red
   // world point stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata   // world_x, world_y, world_z,
                                                 // point_blue, point_green, point_red
);

   localparam int P = PIXEL_INDEX_BITS;

   logic [31:0]             principal_point_ff;
   logic [63:0]             inverse_focal_ff;
   logic [31:0]             inverse_depth_scale_ff;
   logic [ROT_ROW_BITS-1:0] rotation_row_ff [3];
   logic [63:0]             translation_xy_ff;
   logic [31:0]             translation_z_ff;

   cam_cfg_type   cam_cfg;
   pose_cfg_type  pose_cfg;
   color_type     req_color;
   cam_point_type cam_point, world_point;
   logic          cam_valid, cam_ready;

   // Register file: write the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         principal_point_ff     <= PRINCIPAL_POINT_RST;
         inverse_focal_ff       <= INVERSE_FOCAL_RST;
         inverse_depth_scale_ff <= INVERSE_DEPTH_SCALE_RST;
         rotation_row_ff[0]     <= ROTATION_ROW_X_RST;
         rotation_row_ff[1]     <= ROTATION_ROW_Y_RST;
         rotation_row_ff[2]     <= ROTATION_ROW_Z_RST;
         translation_xy_ff      <= '0;
         translation_z_ff       <= '0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            REG_PRINCIPAL_POINT: begin
               principal_point_ff <= csr_write_data[31:0];
            end
            REG_INVERSE_FOCAL: begin
               inverse_focal_ff <= csr_write_data;
            end
            REG_INVERSE_DEPTH_SCALE: begin
               inverse_depth_scale_ff <= csr_write_data[31:0];
            end
            REG_ROTATION_ROW_X: begin
               rotation_row_ff[0] <= csr_write_data[ROT_ROW_BITS-1:0];
            end
            REG_ROTATION_ROW_Y: begin
               rotation_row_ff[1] <= csr_write_data[ROT_ROW_BITS-1:0];
            end
            REG_ROTATION_ROW_Z: begin
               rotation_row_ff[2] <= csr_write_data[ROT_ROW_BITS-1:0];
            end
            REG_TRANSLATION_XY: begin
               translation_xy_ff <= csr_write_data;
            end
            REG_TRANSLATION_Z: begin
               translation_z_ff <= csr_write_data[31:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Unpack registers into the configuration structs
   always_comb begin
      cam_cfg.cx              = principal_point_ff[15:0];
      cam_cfg.cy              = principal_point_ff[31:16];
      cam_cfg.inv_fx          = $signed(inverse_focal_ff[31:0]);
      cam_cfg.inv_fy          = $signed(inverse_focal_ff[63:32]);
      cam_cfg.inv_depth_scale = inverse_depth_scale_ff;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pose_cfg.rot[i][j] = rotation_row_ff[i][ROT_BITS*j +: ROT_BITS];
         end
      end
      pose_cfg.trans[0] = translation_xy_ff[31:0];
      pose_cfg.trans[1] = translation_xy_ff[63:32];
      pose_cfg.trans[2] = translation_z_ff;
   end

   assign req_color.blue  = req_tdata[2*P+DEPTH_BITS +: COLOR_BITS];
   assign req_color.green = req_tdata[2*P+DEPTH_BITS+COLOR_BITS +: COLOR_BITS];
   assign req_color.red   = req_tdata[2*P+DEPTH_BITS+2*COLOR_BITS +: COLOR_BITS];

   dp2w_backproject #(
      .PIXEL_INDEX_BITS (PIXEL_INDEX_BITS)
   ) u_backproject (
      .clock     (clock),
      .reset     (reset),
      .cam_cfg   (cam_cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_column (req_tdata[P-1:0]),
      .in_row    (req_tdata[2*P-1:P]),
      .in_depth  (req_tdata[2*P +: DEPTH_BITS]),
      .in_color  (req_color),
      .out_valid (cam_valid),
      .out_ready (cam_ready),
      .out_point (cam_point)
   );

   dp2w_transform u_transform (
      .clock     (clock),
      .reset     (reset),
      .pose_cfg  (pose_cfg),
      .in_valid  (cam_valid),
      .in_ready  (cam_ready),
      .in_point  (cam_point),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_point (world_point)
   );

   assign rsp_tdata = {world_point.color.red, world_point.color.green,
                       world_point.color.blue, world_point.z, world_point.y,
                       world_point.x};

endmodule
